/* rtl/srrw_pkg.sv */
package srrw_pkg;

  localparam int WINDOW_DEPTH = 8;
  localparam int MAX_PAYLOAD  = 8192;

  localparam int SEQ_W  = 32;
  localparam int LEN_W  = 14;
  localparam int TAG_W  = 16;
  localparam int CFG_W  = 4;
  localparam int KIND_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WIN_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int ENTRY_W = LEN_W + TAG_W;

  localparam logic [KIND_W-1:0] KIND_DATA_ACK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELIVER   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END_ACK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR_ACK = 2'd3;

  localparam logic                REG_WINDOW_SIZE   = 1'b0;
  localparam logic [CFG_W-1:0]    WINDOW_SIZE_RESET = 4'd8;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACK  = 5'b00010,
    ST_READ = 5'b00100,
    ST_DATA = 5'b01000,
    ST_SEND = 5'b10000
  } state_t;

  // circular slot index: ptr + off, both below the depth
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] ptr,
                                                 input logic [SLOT_W-1:0] off);
    logic [SLOT_W:0] sum;
    sum = {1'b0, ptr} + {1'b0, off};
    if (sum >= (SLOT_W+1)'(WINDOW_DEPTH)) begin
      sum = sum - (SLOT_W+1)'(WINDOW_DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [SEQ_W:0] sum;
    sum = {1'b0, a} + (SEQ_W+1)'(b);
    return sum[SEQ_W] ? {SEQ_W{1'b1}} : sum[SEQ_W-1:0];
  endfunction

endpackage

/* rtl/srrw_ram.sv */
module srrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/srrw_cfg.sv */
module srrw_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srrw_pkg::ADDR_W-1:0] paddr,
  input  logic [srrw_pkg::DATA_W-1:0] pwdata,
  output logic [srrw_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [srrw_pkg::WIN_W-1:0]  win_eff
);
  import srrw_pkg::*;

  logic [CFG_W-1:0] window_size;
  logic             hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      window_size <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = hit ? DATA_W'(window_size) : '0;

  // zero acts as one, above the depth acts as the depth
  always_comb begin
    if (window_size == '0) begin
      win_eff = WIN_W'(1);
    end else if (32'(window_size) > 32'(WINDOW_DEPTH)) begin
      win_eff = WIN_W'(WINDOW_DEPTH);
    end else begin
      win_eff = WIN_W'(window_size);
    end
  end

endmodule

/* rtl/selective_repeat_receive_window.sv */
// the first result is registered when the item is accepted and is offered in the next cycle
// each in-order delivery steps through slot memory read, format and hand over
// a new item is taken only in idle, after its acknowledgement and all deliveries are handed over
// reset: window base, byte count and slot valid bits clear, window size becomes 8
// slot memory contents are not cleared; slot contents are only used while marked valid
module selective_repeat_receive_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srrw_pkg::ADDR_W-1:0] paddr,
  input  logic [srrw_pkg::DATA_W-1:0] pwdata,
  output logic [srrw_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [srrw_pkg::SEQ_W-1:0]  seq_number,
  input  logic [srrw_pkg::LEN_W-1:0]  payload_length,
  input  logic [srrw_pkg::TAG_W-1:0]  payload_tag,
  input  logic                        checksum_good,
  input  logic                        end_marker,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [srrw_pkg::KIND_W-1:0] result_kind,
  output logic [srrw_pkg::SEQ_W-1:0]  ack_number,
  output logic [srrw_pkg::TAG_W-1:0]  deliver_tag,
  output logic [srrw_pkg::LEN_W-1:0]  deliver_length,
  output logic [srrw_pkg::SEQ_W-1:0]  byte_offset,
  output logic                        last_result
);
  import srrw_pkg::*;

  state_t                  state;
  logic [SEQ_W-1:0]        base;
  logic [SLOT_W-1:0]       base_ptr;
  logic [SEQ_W-1:0]        bytes;
  logic [WINDOW_DEPTH-1:0] slot_valid;

  logic [WIN_W-1:0]        win_eff;
  logic                    in_take;
  logic                    out_take;
  logic [SEQ_W-1:0]        seq_off;
  logic                    in_win;
  logic                    store;
  logic [SLOT_W-1:0]       phys;
  logic [SLOT_W-1:0]       ptr_inc;
  logic                    ack_last;
  logic                    deliver_last;
  logic [LEN_W-1:0]        len_sat;
  logic [ENTRY_W-1:0]      rdata;

  srrw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .win_eff (win_eff)
  );

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_ACK) || (state == ST_SEND);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  assign seq_off = seq_number - base;
  assign in_win  = (seq_off < SEQ_W'(win_eff));
  assign store   = in_take && checksum_good && !end_marker && in_win;
  assign phys    = slot_add(base_ptr, seq_off[SLOT_W-1:0]);
  assign ptr_inc = slot_add(base_ptr, SLOT_W'(1));
  assign len_sat = (32'(payload_length) > 32'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                            : payload_length;

  assign ack_last     = !(in_win && ((phys == base_ptr) || slot_valid[base_ptr]));
  assign deliver_last = !(slot_valid[ptr_inc] && (ptr_inc != base_ptr));

  srrw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (store),
    .waddr (phys),
    .wdata ({len_sat, payload_tag}),
    .raddr (base_ptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      base       <= '0;
      base_ptr   <= '0;
      bytes      <= '0;
      slot_valid <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            state <= ST_ACK;
          end
          if (store) begin
            slot_valid[phys] <= 1'b1;
          end
        end
        ST_ACK: begin
          if (out_take) begin
            state <= last_result ? ST_IDLE : ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_DATA;
        end
        ST_DATA: begin
          state                <= ST_SEND;
          slot_valid[base_ptr] <= 1'b0;
          base                 <= base + SEQ_W'(1);
          base_ptr             <= ptr_inc;
          bytes                <= sat_add(bytes, rdata[ENTRY_W-1:TAG_W]);
        end
        ST_SEND: begin
          if (out_take) begin
            state <= last_result ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      deliver_tag    <= '0;
      deliver_length <= '0;
      if (!checksum_good) begin
        result_kind <= KIND_ERROR_ACK;
        ack_number  <= '0;
        byte_offset <= '0;
        last_result <= 1'b1;
      end else if (end_marker) begin
        result_kind <= KIND_END_ACK;
        ack_number  <= '0;
        byte_offset <= bytes;
        last_result <= 1'b1;
      end else begin
        result_kind <= KIND_DATA_ACK;
        ack_number  <= seq_number;
        byte_offset <= '0;
        last_result <= ack_last;
      end
    end else if (state == ST_DATA) begin
      result_kind    <= KIND_DELIVER;
      ack_number     <= base;
      deliver_tag    <= rdata[TAG_W-1:0];
      deliver_length <= rdata[ENTRY_W-1:TAG_W];
      byte_offset    <= bytes;
      last_result    <= deliver_last;
    end
  end

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |-> !out_valid)
    else $error("item accepted while a result is pending");

  a_base_steps_on_delivery: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DATA) |=> (base == $past(base) + SEQ_W'(1)) && !slot_valid[$past(base_ptr)])
    else $error("window base did not advance past the delivered slot");

  a_bytes_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (bytes >= $past(bytes)))
    else $error("delivered byte count went down");

  a_base_held_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && !$past(rst) |=> $stable(base) && $stable(bytes))
    else $error("window state changed outside delivery");

endmodule
